FILE: src/bsps_pkg.sv
// ----------------------------------------------------------------------------
// bsps_pkg: brush stamp pixel stream shared definitions
// Field widths, register codes, the brush shape codes, the geometry record
// and the brush cell match used by the pixel path.
// ----------------------------------------------------------------------------
package bsps_pkg;

    // payload and state widths
    localparam int PIX_W      = 32;
    localparam int DIM_W      = 13;
    localparam int CUR_W      = 15;
    localparam int SHAPE_W    = 2;
    localparam int IDX_W      = 24;
    localparam int CTR_W      = 25;
    localparam int DIFF_W     = IDX_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // geometry record widths, sized for the largest supported frame
    localparam int OFF_W = 15;
    localparam int TOT_W = 27;

    // defaults and fixed scale
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_DIM      = 64;
    localparam int CURSOR_FULL    = 25600;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_CURSOR_X     = 3'd2,
        REG_CURSOR_Y     = 3'd3,
        REG_BRUSH_SHAPE  = 3'd4,
        REG_ERASE_MODE   = 3'd5,
        REG_BRUSH_COLOR  = 3'd6
    } t_reg_idx;

    // brush shape codes
    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_NONE   = 2'd0,
        SHAPE_SQ3    = 2'd1,
        SHAPE_SQ5    = 2'd2,
        SHAPE_ROUND7 = 2'd3
    } t_shape;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [CUR_W-1:0] cursor_x_pos;
        logic [CUR_W-1:0] cursor_y_pos;
        t_shape           brush_shape;
        logic             erase_mode;
        logic [PIX_W-1:0] brush_color;
    } t_cfg;

    // brush center, frame size and row strides from the geometry pipeline
    typedef struct packed {
        logic [CTR_W-1:0] center;
        logic [TOT_W-1:0] total_m1;
        logic [OFF_W-1:0] off1;
        logic [OFF_W-1:0] off2;
        logic [OFF_W-1:0] off3;
    } t_geom;

    typedef struct packed {
        logic       on;
        logic [2:0] reach;
    } t_reach;

    // half width of the brush row at distance a from the center row
    function automatic t_reach row_reach(input t_shape shape, input logic [1:0] a);
        t_reach r;
        r.on    = 1'b0;
        r.reach = 3'd0;
        case (shape)
            SHAPE_SQ3: begin
                r.on    = (a <= 2'd1);
                r.reach = 3'd1;
            end
            SHAPE_SQ5: begin
                r.on    = (a <= 2'd2);
                r.reach = 3'd2;
            end
            SHAPE_ROUND7: begin
                r.on = 1'b1;
                case (a)
                    2'd0, 2'd1: r.reach = 3'd3;
                    2'd2:       r.reach = 3'd2;
                    default:    r.reach = 3'd0;
                endcase
            end
            default: begin
                r.on    = 1'b0;
                r.reach = 3'd0;
            end
        endcase
        return r;
    endfunction

    // linear offset from the center hits a brush cell, rows wrap at row ends
    function automatic logic in_brush(input logic signed [DIFF_W-1:0] diff,
                                      input t_geom g, input t_shape shape);
        logic signed [DIFF_W:0] dext;
        logic signed [DIFF_W:0] offs [7];
        logic signed [DIFF_W:0] t;
        logic signed [DIFF_W:0] rs;
        t_reach                 rr;
        logic                   hit;
        dext    = {diff[DIFF_W-1], diff};
        offs[0] = $signed((DIFF_W+1)'(g.off3));
        offs[1] = $signed((DIFF_W+1)'(g.off2));
        offs[2] = $signed((DIFF_W+1)'(g.off1));
        offs[3] = '0;
        offs[4] = -$signed((DIFF_W+1)'(g.off1));
        offs[5] = -$signed((DIFF_W+1)'(g.off2));
        offs[6] = -$signed((DIFF_W+1)'(g.off3));
        hit     = 1'b0;
        for (int i = 0; i < 7; i++) begin
            t   = dext + offs[i];
            rr  = row_reach(shape, 2'((i < 3) ? (3 - i) : (i - 3)));
            rs  = $signed((DIFF_W+1)'(rr.reach));
            hit = hit | (rr.on && (t <= rs) && (t >= -rs));
        end
        return hit;
    endfunction

endpackage

FILE: src/bsps_cfg_if.sv
// ----------------------------------------------------------------------------
// bsps_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsps_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bsps_pkg::CFG_IDX_W-1:0]      index;
    logic [bsps_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/bsps_pix_in_if.sv
// ----------------------------------------------------------------------------
// bsps_pix_in_if: input pixel channel
// One item carries the current pixel and the default pixel.
// ----------------------------------------------------------------------------
interface bsps_pix_in_if;
    logic                          valid;
    logic                          ready;
    logic [bsps_pkg::PIX_W-1:0]    current_pixel;
    logic [bsps_pkg::PIX_W-1:0]    default_pixel;

    modport source (output valid, output current_pixel, output default_pixel, input ready);
    modport sink   (input valid, input current_pixel, input default_pixel, output ready);
endinterface

FILE: src/bsps_pix_out_if.sv
// ----------------------------------------------------------------------------
// bsps_pix_out_if: result pixel channel
// One item carries the resulting pixel, the brush hit flag and end of frame.
// ----------------------------------------------------------------------------
interface bsps_pix_out_if;
    logic                          valid;
    logic                          ready;
    logic [bsps_pkg::PIX_W-1:0]    pixel_out;
    logic                          inside_brush;
    logic                          last_pixel;

    modport source (output valid, output pixel_out, output inside_brush, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_out, input inside_brush, input last_pixel,
                    output ready);
endinterface

FILE: src/brush_stamp_pixel_stream.sv
// Path: an accepted item passes the pipeline stages, then the output register.
// Throughput: one item per cycle while results are taken; while one waits,
// four pipeline stages and the output register take items until all are full.
// Reset: registers return to 64x64, cursor 0, no brush; the frame index and
// latched center clear. The center for a new frame comes from a three-stage
// geometry pipeline and is latched when the first pixel of the frame passes.
// ----------------------------------------------------------------------------
// brush_stamp_pixel_stream: brush stamp over a raster pixel stream
// Counts the pixel index, latches the brush center at each frame start and
// replaces pixels whose linear offset from the center hits a brush cell.
// ----------------------------------------------------------------------------
module brush_stamp_pixel_stream #(
    parameter int MAX_WIDTH  = bsps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsps_pkg::DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsps_cfg_if.sink              i_cfg,
    bsps_pix_in_if.sink           i_pix,
    bsps_pix_out_if.source        o_pix
);

    localparam int NSTG = 4;

    bsps_pkg::t_cfg                     r_cfg;
    bsps_pkg::t_geom                    geom;
    logic                               r_run;
    logic [NSTG-1:0]                    r_valid;
    logic [NSTG-1:0]                    rdy;
    logic [NSTG-1:0]                    mv;
    logic                               out_free;
    logic                               acc;
    logic [bsps_pkg::PIX_W-1:0]         r_cur [NSTG];
    logic [bsps_pkg::PIX_W-1:0]         r_def [NSTG];
    logic [bsps_pkg::IDX_W-1:0]         r_pixel_index;
    logic [bsps_pkg::CTR_W-1:0]         r_center;
    logic signed [bsps_pkg::DIFF_W-1:0] r_diff;
    logic                               r_last;
    logic                               r_out_valid;
    logic [bsps_pkg::PIX_W-1:0]         r_out_pixel;
    logic                               r_out_inside;
    logic                               r_out_last;

    logic [bsps_pkg::CTR_W-1:0]         n_center;
    logic                               n_last;
    logic [bsps_pkg::IDX_W-1:0]         n_index;
    logic signed [bsps_pkg::DIFF_W-1:0] n_diff;
    logic                               n_inside;
    logic [bsps_pkg::PIX_W-1:0]         n_pixel;

    // geometry from the configuration
    bsps_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .i_clk  (i_clk),
        .i_cfg  (r_cfg),
        .o_geom (geom)
    );

    // stage handshake: a stage moves when the next one is empty or moving
    always_comb begin
        out_free       = !r_out_valid || o_pix.ready;
        rdy[NSTG-1]    = !r_valid[NSTG-1] || out_free;
        mv[NSTG-1]     = r_valid[NSTG-1] && out_free;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
            mv[k]  = r_valid[k] && rdy[k+1];
        end
    end

    assign i_pix.ready = r_run && rdy[0];
    assign i_cfg.ready = r_run;
    assign acc         = i_pix.valid && i_pix.ready;

    // frame index, center latch and offset from the center
    always_comb begin
        n_center = (r_pixel_index == '0) ? geom.center : r_center;
        n_last   = bsps_pkg::TOT_W'(r_pixel_index) >= geom.total_m1;
        n_index  = n_last ? '0 : r_pixel_index + 1'b1;
        n_diff   = $signed({2'b00, r_pixel_index}) - $signed({1'b0, n_center});
    end

    // brush match and pixel select
    always_comb begin
        n_inside = bsps_pkg::in_brush(r_diff, geom, r_cfg.brush_shape);
        n_pixel  = n_inside ? (r_cfg.erase_mode ? r_def[NSTG-1] : r_cfg.brush_color)
                            : r_cur[NSTG-1];
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run         <= 1'b0;
            r_valid       <= '0;
            r_out_valid   <= 1'b0;
            r_pixel_index <= '0;
            r_center      <= '0;
            r_cfg         <= '{image_width:  bsps_pkg::DIM_W'(bsps_pkg::RESET_DIM),
                               image_height: bsps_pkg::DIM_W'(bsps_pkg::RESET_DIM),
                               cursor_x_pos: '0,
                               cursor_y_pos: '0,
                               brush_shape:  bsps_pkg::SHAPE_NONE,
                               erase_mode:   1'b0,
                               brush_color:  '0};
        end else begin
            r_run <= 1'b1;
            if (i_cfg.valid && i_cfg.ready) begin
                case (bsps_pkg::t_reg_idx'(i_cfg.index))
                    bsps_pkg::REG_IMAGE_WIDTH: begin
                        r_cfg.image_width <= i_cfg.data[bsps_pkg::DIM_W-1:0];
                    end
                    bsps_pkg::REG_IMAGE_HEIGHT: begin
                        r_cfg.image_height <= i_cfg.data[bsps_pkg::DIM_W-1:0];
                    end
                    bsps_pkg::REG_CURSOR_X: begin
                        r_cfg.cursor_x_pos <= i_cfg.data[bsps_pkg::CUR_W-1:0];
                    end
                    bsps_pkg::REG_CURSOR_Y: begin
                        r_cfg.cursor_y_pos <= i_cfg.data[bsps_pkg::CUR_W-1:0];
                    end
                    bsps_pkg::REG_BRUSH_SHAPE: begin
                        r_cfg.brush_shape <=
                            bsps_pkg::t_shape'(i_cfg.data[bsps_pkg::SHAPE_W-1:0]);
                    end
                    bsps_pkg::REG_ERASE_MODE: begin
                        r_cfg.erase_mode <= i_cfg.data[0];
                    end
                    bsps_pkg::REG_BRUSH_COLOR: begin
                        r_cfg.brush_color <= i_cfg.data[bsps_pkg::PIX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // stage valid bits
            if (acc) begin
                r_valid[0] <= 1'b1;
            end else if (mv[0]) begin
                r_valid[0] <= 1'b0;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (mv[k-1]) begin
                    r_valid[k] <= 1'b1;
                end else if (mv[k]) begin
                    r_valid[k] <= 1'b0;
                end
            end
            if (mv[NSTG-1]) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            // index and center advance as an item enters the last stage
            if (mv[NSTG-2]) begin
                r_pixel_index <= n_index;
                r_center      <= n_center;
            end
        end
    end

    // item payload through the stages
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cur[0] <= i_pix.current_pixel;
            r_def[0] <= i_pix.default_pixel;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (mv[k-1]) begin
                r_cur[k] <= r_cur[k-1];
                r_def[k] <= r_def[k-1];
            end
        end
        if (mv[NSTG-2]) begin
            r_diff <= n_diff;
            r_last <= n_last;
        end
        if (mv[NSTG-1]) begin
            r_out_pixel  <= n_pixel;
            r_out_inside <= n_inside;
            r_out_last   <= r_last;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_out    = r_out_pixel;
    assign o_pix.inside_brush = r_out_inside;
    assign o_pix.last_pixel   = r_out_last;

    // center stays latched except at the first pixel of a frame
    a_center_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mv[NSTG-2] && r_pixel_index == '0) |=> $stable(r_center))
        else $error("brush center changed inside a frame");

    // the index wraps to zero after the last pixel
    a_index_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv[NSTG-2] && n_last) |=> (r_pixel_index == '0))
        else $error("pixel index did not wrap after last pixel");

    // input stalls only when every stage and the output register are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && !i_pix.ready) |-> ((&r_valid) && r_out_valid && !o_pix.ready))
        else $error("input stalled with room in the pipeline");

    // no brush shape, no hit
    a_no_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mv[NSTG-1] && n_inside) |-> (r_cfg.brush_shape != bsps_pkg::SHAPE_NONE))
        else $error("brush hit with no brush shape");

endmodule

FILE: src/bsps_geom.sv
// ----------------------------------------------------------------------------
// bsps_geom: brush geometry pipeline
// Three free-running stages turn the configuration into the brush center
// index, the last pixel index of the frame and the row strides.
// ----------------------------------------------------------------------------
module bsps_geom #(
    parameter int MAX_WIDTH  = bsps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bsps_pkg::DEF_MAX_HEIGHT
) (
    input  logic            i_clk,
    input  bsps_pkg::t_cfg  i_cfg,
    output bsps_pkg::t_geom o_geom
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    // product with the cursor after the divide by 256
    localparam int XW = WW + bsps_pkg::CUR_W - 8;
    localparam int YW = HW + bsps_pkg::CUR_W - 8;
    // divide by 100 as a multiply by a rounded-up reciprocal, exact for XW bits
    localparam int KX = XW + 7;
    localparam int KY = YW + 7;
    localparam longint unsigned MXL = ((64'd1 << KX) + 64'd99) / 64'd100;
    localparam longint unsigned MYL = ((64'd1 << KY) + 64'd99) / 64'd100;
    localparam logic [KX-7:0] MX = MXL[KX-7:0];
    localparam logic [KY-7:0] MY = MYL[KY-7:0];
    localparam int CSW = (WW + HW + 1 > bsps_pkg::CTR_W) ? (WW + HW + 1) : bsps_pkg::CTR_W;
    localparam logic [bsps_pkg::DIM_W:0] MAXW = (bsps_pkg::DIM_W + 1)'(MAX_WIDTH);
    localparam logic [bsps_pkg::DIM_W:0] MAXH = (bsps_pkg::DIM_W + 1)'(MAX_HEIGHT);
    localparam logic [bsps_pkg::CUR_W-1:0] CFULL = bsps_pkg::CUR_W'(bsps_pkg::CURSOR_FULL);

    logic [WW-1:0]                 n_wc;
    logic [HW-1:0]                 n_hc;
    logic [bsps_pkg::CUR_W-1:0]    n_cxs;
    logic [bsps_pkg::CUR_W-1:0]    n_cys;
    logic [WW+HW-1:0]              n_total;
    logic [XW+KX-7:0]              n_qx;
    logic [YW+KY-7:0]              n_qy;
    logic [WW+HW-1:0]              n_prod;
    logic [CSW-1:0]                n_sum;

    logic [WW-1:0]                 r_wc;
    logic [WW+bsps_pkg::CUR_W-1:0] r_px;
    logic [HW+bsps_pkg::CUR_W-1:0] r_py;
    logic [bsps_pkg::TOT_W-1:0]    r_total_m1;
    logic [WW-1:0]                 r_cx;
    logic [HW-1:0]                 r_cy;
    logic [WW-1:0]                 r_w2;
    logic [bsps_pkg::OFF_W-1:0]    r_off1;
    logic [bsps_pkg::OFF_W-1:0]    r_off2;
    logic [bsps_pkg::OFF_W-1:0]    r_off3;
    logic [bsps_pkg::CTR_W-1:0]    r_center;

    // clamp size and cursor to their legal ranges
    always_comb begin
        if (i_cfg.image_width == '0) begin
            n_wc = WW'(1);
        end else if ({1'b0, i_cfg.image_width} > MAXW) begin
            n_wc = WW'(MAX_WIDTH);
        end else begin
            n_wc = WW'(i_cfg.image_width);
        end
        if (i_cfg.image_height == '0) begin
            n_hc = HW'(1);
        end else if ({1'b0, i_cfg.image_height} > MAXH) begin
            n_hc = HW'(MAX_HEIGHT);
        end else begin
            n_hc = HW'(i_cfg.image_height);
        end
        n_cxs   = (i_cfg.cursor_x_pos > CFULL) ? CFULL : i_cfg.cursor_x_pos;
        n_cys   = (i_cfg.cursor_y_pos > CFULL) ? CFULL : i_cfg.cursor_y_pos;
        n_total = n_wc * n_hc;
    end

    // reciprocal multiply for the column and row of the center
    always_comb begin
        n_qx = r_px[WW+bsps_pkg::CUR_W-1:8] * MX;
        n_qy = r_py[HW+bsps_pkg::CUR_W-1:8] * MY;
    end

    // center index cy*W+cx
    always_comb begin
        n_prod = r_cy * r_w2;
        n_sum  = CSW'(n_prod) + CSW'(r_cx);
    end

    // pipeline registers, no control state here
    always_ff @(posedge i_clk) begin
        r_wc       <= n_wc;
        r_px       <= n_wc * n_cxs;
        r_py       <= n_hc * n_cys;
        r_total_m1 <= bsps_pkg::TOT_W'(n_total - 1'b1);
        r_cx       <= n_qx[KX +: WW];
        r_cy       <= n_qy[KY +: HW];
        r_w2       <= r_wc;
        r_off1     <= bsps_pkg::OFF_W'(r_wc);
        r_off2     <= bsps_pkg::OFF_W'({r_wc, 1'b0});
        r_off3     <= bsps_pkg::OFF_W'({r_wc, 1'b0}) + bsps_pkg::OFF_W'(r_wc);
        r_center   <= n_sum[bsps_pkg::CTR_W-1:0];
    end

    assign o_geom = '{center:   r_center,
                      total_m1: r_total_m1,
                      off1:     r_off1,
                      off2:     r_off2,
                      off3:     r_off3};

endmodule
